[rtl/slt_pkg.sv]
// ---------------------------------------------------------------------------
// Shell line tokenizer package
// Shared character codes, token kinds and result types.
// ---------------------------------------------------------------------------
package slt_pkg;

  localparam logic [7:0] CH_PIPE  = 8'h7C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_DQ    = 8'h22;
  localparam logic [7:0] CH_SQ    = 8'h27;

  localparam int QDepth = 4;
  localparam int QAw    = $clog2(QDepth);

  typedef enum logic [2:0] {
    K_WORD    = 3'd0,
    K_PIPE    = 3'd1,
    K_RIN     = 3'd2,
    K_ROUT    = 3'd3,
    K_HEREDOC = 3'd4,
    K_APPEND  = 3'd5,
    K_EOL     = 3'd6
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic       has;
    logic       st;
    logic       en;
    logic       last;
  } res_t;

  typedef struct packed {
    logic two;
    res_t r1;
    res_t r0;
  } entry_t;

  function automatic res_t mk_res(kind_t k, logic [7:0] b, logic h, logic s, logic e);
    res_t r;
    r.kind = k;
    r.data = b;
    r.has  = h;
    r.st   = s;
    r.en   = e;
    r.last = 1'b0;
    return r;
  endfunction

endpackage

[rtl/slt_lexer.sv]
// ---------------------------------------------------------------------------
// Shell line tokenizer front end
// Accepts one byte per cycle while the queue is not full, tracks the lexer
// state and forms up to two results per byte as one queue entry.
// ---------------------------------------------------------------------------
module slt_lexer import slt_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,
  input  logic       in_tlast,
  input  logic       q_full,
  output logic       q_push,
  output entry_t     q_data
);

  typedef enum logic [2:0] {
    M_IDLE  = 3'd0,
    M_WORD  = 3'd1,
    M_SQ    = 3'd2,
    M_DQ    = 3'd3,
    M_REDIR = 3'd4
  } mode_t;

  mode_t      mode_r, mode_nxt;
  logic [7:0] held_char_r, held_char_nxt;
  logic       held_valid_r, held_valid_nxt;
  logic       open_r, open_nxt;
  logic       esc_r, esc_nxt;
  logic       rout_r, rout_nxt;

  logic       accept;
  logic [7:0] c;
  logic       is_sep;
  logic       do_fin, do_idle, do_add, do_pair, do_eol;
  logic [1:0] n;
  res_t       res_a [2];
  kind_t      pk;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;
  assign c         = in_tdata;
  assign is_sep    = (c == CH_SPACE) || (c == CH_SQ) || (c == CH_DQ) || (c == CH_PIPE) ||
                     (c == CH_LT) || (c == CH_GT);

  always_comb begin
    mode_nxt       = mode_r;
    held_char_nxt  = held_char_r;
    held_valid_nxt = held_valid_r;
    open_nxt       = open_r;
    esc_nxt        = esc_r;
    rout_nxt       = rout_r;
    n              = 2'd0;
    res_a[0]       = '0;
    res_a[1]       = '0;
    do_fin         = 1'b0;
    do_idle        = 1'b0;
    do_add         = 1'b0;
    do_pair        = 1'b0;
    do_eol         = 1'b0;
    pk             = rout_r ? K_APPEND : K_HEREDOC;

    if (in_tlast) begin
      do_fin = 1'b1;
      do_eol = 1'b1;
    end else begin
      case (mode_r)
        M_WORD: begin
          if (is_sep) begin
            do_fin  = 1'b1;
            do_idle = 1'b1;
          end else begin
            do_add = 1'b1;
          end
        end
        M_SQ: begin
          if (c == CH_SQ) do_fin = 1'b1;
          else do_add = 1'b1;
        end
        M_DQ: begin
          if (esc_r) begin
            esc_nxt = 1'b0;
            do_add  = 1'b1;
          end else if (c == CH_DQ) begin
            do_fin = 1'b1;
          end else begin
            esc_nxt = (c == CH_BSL);
            do_add  = 1'b1;
          end
        end
        M_REDIR: begin
          if (c == held_char_r) begin
            do_pair = 1'b1;
          end else begin
            do_fin  = 1'b1;
            do_idle = 1'b1;
          end
        end
        default: do_idle = 1'b1;
      endcase
    end

    if (do_pair) begin
      res_a[0] = mk_res(pk, held_char_r, 1'b1, 1'b1, 1'b0);
      res_a[1] = mk_res(pk, c, 1'b1, 1'b0, 1'b1);
      n        = 2'd2;
      mode_nxt       = M_IDLE;
      held_char_nxt  = '0;
      held_valid_nxt = 1'b0;
      open_nxt       = 1'b0;
      esc_nxt        = 1'b0;
      rout_nxt       = 1'b0;
    end

    if (do_fin) begin
      case (mode_r)
        M_REDIR: begin
          res_a[0] = mk_res(rout_r ? K_ROUT : K_RIN, held_char_r, 1'b1, 1'b1, 1'b1);
          n        = 2'd1;
        end
        M_WORD, M_SQ, M_DQ: begin
          if (held_valid_r) res_a[0] = mk_res(K_WORD, held_char_r, 1'b1, !open_r, 1'b1);
          else res_a[0] = mk_res(K_WORD, 8'd0, 1'b0, 1'b1, 1'b1);
          n = 2'd1;
        end
        default: n = 2'd0;
      endcase
      mode_nxt       = M_IDLE;
      held_char_nxt  = '0;
      held_valid_nxt = 1'b0;
      open_nxt       = 1'b0;
      esc_nxt        = 1'b0;
      rout_nxt       = 1'b0;
    end

    if (do_add) begin
      if (held_valid_r) begin
        res_a[0] = mk_res(K_WORD, held_char_r, 1'b1, !open_r, 1'b0);
        n        = 2'd1;
        open_nxt = 1'b1;
      end
      held_char_nxt  = c;
      held_valid_nxt = 1'b1;
    end

    if (do_idle) begin
      mode_nxt       = M_IDLE;
      held_char_nxt  = '0;
      held_valid_nxt = 1'b0;
      open_nxt       = 1'b0;
      esc_nxt        = 1'b0;
      rout_nxt       = 1'b0;
      if (c == CH_SPACE) begin
        mode_nxt = M_IDLE;
      end else if (c == CH_SQ) begin
        mode_nxt = M_SQ;
      end else if (c == CH_DQ) begin
        mode_nxt = M_DQ;
      end else if (c == CH_PIPE) begin
        res_a[n[0]] = mk_res(K_PIPE, c, 1'b1, 1'b1, 1'b1);
        n           = n + 2'd1;
      end else if ((c == CH_LT) || (c == CH_GT)) begin
        mode_nxt       = M_REDIR;
        held_char_nxt  = c;
        held_valid_nxt = 1'b1;
        rout_nxt       = (c == CH_GT);
      end else begin
        mode_nxt       = M_WORD;
        held_char_nxt  = c;
        held_valid_nxt = 1'b1;
      end
    end

    if (do_eol) begin
      res_a[n[0]] = mk_res(K_EOL, 8'd0, 1'b0, 1'b1, 1'b1);
      n           = n + 2'd1;
    end

    if (n == 2'd1) res_a[0].last = 1'b1;
    if (n == 2'd2) res_a[1].last = 1'b1;
  end

  assign q_push      = accept && (n != 2'd0);
  assign q_data.two  = n[1];
  assign q_data.r0   = res_a[0];
  assign q_data.r1   = res_a[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= M_IDLE;
      held_char_r  <= '0;
      held_valid_r <= 1'b0;
      open_r       <= 1'b0;
      esc_r        <= 1'b0;
      rout_r       <= 1'b0;
    end else if (accept) begin
      mode_r       <= mode_nxt;
      held_char_r  <= held_char_nxt;
      held_valid_r <= held_valid_nxt;
      open_r       <= open_nxt;
      esc_r        <= esc_nxt;
      rout_r       <= rout_nxt;
    end
  end

endmodule

[rtl/slt_queue.sv]
// ---------------------------------------------------------------------------
// Shell line tokenizer entry queue
// Small first-in first-out buffer between the front and back ends.
// ---------------------------------------------------------------------------
module slt_queue import slt_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  entry_t push_data,
  output logic   full,
  input  logic   pop,
  output entry_t pop_data,
  output logic   empty
);

  entry_t           mem_r [QDepth];
  logic [QAw-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QAw:0]     cnt_r;
  logic             do_push, do_pop;

  assign full     = (cnt_r == (QAw+1)'(QDepth));
  assign empty    = (cnt_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

[rtl/slt_emitter.sv]
// ---------------------------------------------------------------------------
// Shell line tokenizer back end
// Splits queue entries into single results and drives the output register.
// ---------------------------------------------------------------------------
module slt_emitter import slt_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_empty,
  input  entry_t     q_data,
  output logic       q_pop,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,
  output logic [5:0] out_tuser,
  output logic       out_tlast
);

  entry_t cur_r;
  logic   cur_valid_r;
  logic   phase_r;
  res_t   out_r;
  logic   out_valid_r;
  logic   load;
  logic   consume;
  res_t   sel;

  assign load    = cur_valid_r && (!out_valid_r || out_tready);
  assign consume = load && (phase_r || !cur_r.two);
  assign q_pop   = !q_empty && (!cur_valid_r || consume);
  assign sel     = phase_r ? cur_r.r1 : cur_r.r0;

  always_ff @(posedge clk) begin
    if (q_pop) cur_r <= q_data;
    if (load) out_r <= sel;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      phase_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        cur_valid_r <= 1'b1;
        phase_r     <= 1'b0;
      end else if (consume) begin
        cur_valid_r <= 1'b0;
        phase_r     <= 1'b0;
      end else if (load) begin
        phase_r <= 1'b1;
      end
      if (load) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_r.data;
  assign out_tuser  = {out_r.en, out_r.st, out_r.has, out_r.kind};
  assign out_tlast  = out_r.last;

endmodule

[rtl/shell_line_tokenizer.sv]
// ---------------------------------------------------------------------------
// Shell line tokenizer
// Splits a command line, given byte by byte, into word and operator tokens.
//
// The input stream carries one character per transaction in in_tdata; a
// transaction with in_tlast high ends the line and its data is ignored.
// The output stream carries one token byte per transaction. out_tuser tells
// the token kind, whether out_tdata holds content, and the token start and
// end flags; out_tlast marks the last result caused by one input byte.
// An input byte gives zero, one or two results. The front end takes one byte
// per cycle while the four-entry queue has room; the back end sends one result
// per cycle while the receiver is ready. When the queue and the back end are
// empty, the first result of a byte passes the queue, the current-entry
// register and the output register before it is presented. Because the last
// content byte of a word is held until the word ends, its result appears
// only with the byte that ends the word.
// Synchronous reset returns the lexer to its idle state and empties the
// queue and the output register. When the receiver stalls, the output holds
// and the queue fills, after which in_tready falls.
// ---------------------------------------------------------------------------
module shell_line_tokenizer import slt_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  input  logic       in_tlast,   // end_of_line
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic [5:0] out_tuser,  // [2:0] tok_kind, [3] has_byte, [4] tok_start, [5] tok_end
  output logic       out_tlast   // run_last
);

  logic   q_push, q_full, q_pop, q_empty;
  entry_t q_wdata, q_rdata;

  slt_lexer u_lexer (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_wdata)
  );

  slt_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .empty     (q_empty)
  );

  slt_emitter u_emitter (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_data     (q_rdata),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
